// ----- rtl/dmv_pkg.sv -----
// Shared types and constants for the degree/minute position field validator.
// Depends on nothing; imported by dmv_judge and the top level.
`timescale 1ns / 1ps

package dmv_pkg;

   typedef enum logic [1:0] {
      STATUS_MORE    = 2'd0,
      STATUS_ACCEPT  = 2'd1,
      STATUS_REJECT  = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0] char_position;
      logic       field_open;
      logic       longitude_mode;
      logic       space_seen;
      logic [9:0] number_accumulator;
   } state_type;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;
   localparam logic [7:0] CHAR_LO_E  = 8'h65;
   localparam logic [7:0] CHAR_UP_W  = 8'h57;
   localparam logic [7:0] CHAR_LO_W  = 8'h77;
   localparam logic [7:0] CHAR_UP_N  = 8'h4E;
   localparam logic [7:0] CHAR_LO_N  = 8'h6E;
   localparam logic [7:0] CHAR_UP_S  = 8'h53;
   localparam logic [7:0] CHAR_LO_S  = 8'h73;

   localparam logic [9:0] MAX_LAT_DEG = 10'd89;
   localparam logic [9:0] MAX_LON_DEG = 10'd179;
   localparam logic [9:0] MAX_MINUTE  = 10'd59;

   localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
   localparam logic [3:0] LON_DEG_DIGITS = 4'd3;

endpackage

// ----- rtl/dmv_judge.sv -----
// Combinational step of the validator: judges one character against the
// current string state and forms the next state. Depends on dmv_pkg.
`timescale 1ns / 1ps

module dmv_judge (
   input  dmv_pkg::state_type  state,
   input  logic [7:0]          char_in,
   input  logic                start_req,
   input  logic                is_longitude,
   output dmv_pkg::state_type  state_next,
   output dmv_pkg::status_type status
);
   import dmv_pkg::*;

   state_type  cur;
   logic [3:0] nd;
   logic [3:0] pos;
   logic [9:0] acc_base;
   logic [9:0] acc_x10;
   logic [9:0] acc_digit;
   logic [9:0] acc_taken;
   logic [9:0] max_deg;
   logic       is_digit;
   logic       is_space;
   logic       take_ok;
   logic       hemi_ok;
   status_type st;

   always_comb begin
      // A start character opens a fresh string, abandoning any open one.
      if (start_req) begin
         cur.char_position      = 4'd0;
         cur.field_open         = 1'b1;
         cur.longitude_mode     = is_longitude;
         cur.space_seen         = 1'b0;
         cur.number_accumulator = 10'd0;
      end else begin
         cur = state;
      end

      pos     = cur.char_position;
      nd      = cur.longitude_mode ? LON_DEG_DIGITS : LAT_DEG_DIGITS;
      max_deg = cur.longitude_mode ? MAX_LON_DEG : MAX_LAT_DEG;

      // Each digit group starts from zero: degrees, minutes, hundredths.
      if (pos == 4'd0 || pos == nd || pos == nd + 4'd3) begin
         acc_base = 10'd0;
      end else begin
         acc_base = cur.number_accumulator;
      end

      // Times ten as shift and add, wrapping at ten bits.
      acc_x10   = {acc_base[6:0], 3'b000} + {acc_base[8:0], 1'b0};
      acc_digit = acc_x10 + {6'd0, char_in[3:0] - CHAR_ZERO[3:0]};

      is_space = (char_in == CHAR_SPACE);
      is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE) && !cur.space_seen;
      take_ok  = is_digit || is_space;
      acc_taken = is_digit ? acc_digit : acc_x10;

      if (cur.longitude_mode) begin
         hemi_ok = (char_in == CHAR_UP_E) || (char_in == CHAR_LO_E) ||
                   (char_in == CHAR_UP_W) || (char_in == CHAR_LO_W);
      end else begin
         hemi_ok = (char_in == CHAR_UP_N) || (char_in == CHAR_LO_N) ||
                   (char_in == CHAR_UP_S) || (char_in == CHAR_LO_S);
      end

      state_next = cur;
      state_next.number_accumulator = acc_base;
      st = STATUS_REJECT;

      if (!cur.field_open) begin
         state_next = cur;
         st         = STATUS_IGNORED;
      end else begin
         if (pos < nd + 4'd2 || (pos > nd + 4'd2 && pos < nd + 4'd5)) begin
            // Digit position (degrees, minutes or hundredths).
            if (take_ok) begin
               state_next.number_accumulator = acc_taken;
               state_next.space_seen         = cur.space_seen || is_space;
               if (pos == nd - 4'd1 && acc_taken > max_deg) begin
                  st = STATUS_REJECT;
               end else if (pos == nd + 4'd1 && acc_taken > MAX_MINUTE) begin
                  st = STATUS_REJECT;
               end else begin
                  st = STATUS_MORE;
               end
            end else begin
               st = STATUS_REJECT;
            end
         end else if (pos == nd + 4'd2) begin
            // Separator: a dot, or a space while none has been seen.
            if (cur.space_seen) begin
               st = STATUS_REJECT;
            end else if (char_in == CHAR_DOT) begin
               st = STATUS_MORE;
            end else if (is_space) begin
               state_next.space_seen = 1'b1;
               st = STATUS_MORE;
            end else begin
               st = STATUS_REJECT;
            end
         end else if (pos == nd + 4'd5) begin
            st = hemi_ok ? STATUS_ACCEPT : STATUS_REJECT;
         end else begin
            st = STATUS_REJECT;
         end

         if (st == STATUS_MORE) begin
            state_next.char_position = pos + 4'd1;
         end else begin
            state_next.field_open    = 1'b0;
            state_next.char_position = 4'd0;
         end
      end

      status = st;
   end

endmodule

// ----- rtl/degree_minute_field_validator_top.sv -----
// Top level of the degree/minute position field validator: string state
// registers, the judging step and the result register. Depends on dmv_pkg, dmv_judge.
`timescale 1ns / 1ps

// Usage
// The request channel carries one character of a fixed-width position string per
// word: latitude ddmm.mmH or longitude dddmm.mmH. req_tuser bit 0 marks the first
// character of a string, and bit 1, sampled with it, selects longitude.
// Every accepted word yields exactly one response word whose status says: more
// characters needed, accepted on this final character, rejected at this
// character, or ignored because no string is open.
// The verdict for a word accepted at one edge is presented on the response
// channel right after that edge. Throughput is one word per cycle while the
// receiver takes responses; the single pass of compare and multiply-by-ten accumulate
// between the string state registers and the result register sets that figure.
// The response register acts as the output stage: a new request is taken while
// the held response is being taken in the same cycle, so a receiver that keeps
// rsp_tready high never slows the stream. When the receiver stalls, the
// response holds and req_tready drops until it is taken.
// Reset (synchronous, active high) closes any open string, clears the string
// state and empties the response register.

module degree_minute_field_validator_top (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic [1:0] req_tuser,   // [0] start_req, [1] is_longitude
   // Response channel.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] status, [7:2] zero
);
   import dmv_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;
   status_type status_next;
   logic [1:0] status_ff;
   logic [1:0] status_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;

   // The output register can take a new word when empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   dmv_judge u_judge (
      .state        (state_ff),
      .char_in      (req_tdata),
      .start_req    (req_tuser[0]),
      .is_longitude (req_tuser[1]),
      .state_next   (state_next),
      .status       (status_next)
   );

   always_comb begin
      state_in     = req_accept ? state_next : state_ff;
      status_in    = req_accept ? status_next : status_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, status_ff};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for degree_minute_field_validator_top: streams position
// strings and noise into the request channel and checks every response word.
// Depends on dmv_pkg and the RTL top level; a small scoreboard class holds the verdict predictor.
`timescale 1ns / 1ps

module tb_top;
   import dmv_pkg::*;

   localparam int JUDGED_TARGET = 1550;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_IDLE      = 18;

   // Predicts one verdict per accepted character and keeps the verdicts that are
   // still owed by the block, oldest first.
   class verdict_scoreboard;
      logic [3:0] pos;
      bit         open;
      bit         lon;
      bit         spc;
      logic [9:0] acc;
      status_type pending_verdicts[$];
      int         errors;
      int         tally[4];

      function new();
         pos = '0;
         open = 0;
         lon = 0;
         spc = 0;
         acc = '0;
         errors = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      // A digit, or a space that reads as zero; once a space is seen only spaces pass.
      function bit take_digit(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE && !spc) begin
            acc = acc * 10'd10 + 10'(c - CHAR_ZERO);
            return 1;
         end
         if (c == CHAR_SPACE) begin
            acc = acc * 10'd10;
            spc = 1;
            return 1;
         end
         return 0;
      endfunction

      function status_type judge_char(logic [7:0] c);
         int         nd;
         int         p;
         logic [9:0] max_deg;
         nd = lon ? 3 : 2;
         p = pos;
         max_deg = lon ? MAX_LON_DEG : MAX_LAT_DEG;
         if (p == 0 || p == nd || p == nd + 3) acc = '0;
         if (p < nd) begin
            if (!take_digit(c)) return STATUS_REJECT;
            if (p == nd - 1 && acc > max_deg) return STATUS_REJECT;
            return STATUS_MORE;
         end
         if (p < nd + 2) begin
            if (!take_digit(c)) return STATUS_REJECT;
            if (p == nd + 1 && acc > MAX_MINUTE) return STATUS_REJECT;
            return STATUS_MORE;
         end
         if (p == nd + 2) begin
            if (spc) return STATUS_REJECT;
            if (c == CHAR_DOT) return STATUS_MORE;
            if (c == CHAR_SPACE) begin
               spc = 1;
               return STATUS_MORE;
            end
            return STATUS_REJECT;
         end
         if (p < nd + 5) begin
            if (!take_digit(c)) return STATUS_REJECT;
            return STATUS_MORE;
         end
         if (p == nd + 5) begin
            if (lon) begin
               if (c == CHAR_UP_E || c == CHAR_LO_E || c == CHAR_UP_W || c == CHAR_LO_W)
                  return STATUS_ACCEPT;
            end else begin
               if (c == CHAR_UP_N || c == CHAR_LO_N || c == CHAR_UP_S || c == CHAR_LO_S)
                  return STATUS_ACCEPT;
            end
            return STATUS_REJECT;
         end
         return STATUS_REJECT;
      endfunction

      function void note_char(logic [7:0] c, logic start, logic longitude);
         status_type st;
         if (start) begin
            open = 1;
            lon = longitude;
            pos = '0;
            spc = 0;
            acc = '0;
         end
         if (!open) begin
            st = STATUS_IGNORED;
         end else begin
            st = judge_char(c);
            if (st == STATUS_MORE) begin
               pos = pos + 4'd1;
            end else begin
               open = 0;
               pos = '0;
            end
         end
         pending_verdicts.push_back(st);
         tally[st]++;
      endfunction

      function void check_verdict(logic [7:0] word);
         status_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: response word %h with no verdict pending", $time, word);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (word[1:0] !== want) begin
            $display("%0t: status mismatch, expected %s, actual %b", $time, want.name(),
                     word[1:0]);
            errors++;
         end
         if (word[7:2] !== 6'b0) begin
            $display("%0t: padding mismatch, expected 000000, actual %b", $time, word[7:2]);
            errors++;
         end
      endfunction

      function int judged();
         return tally[STATUS_MORE] + tally[STATUS_ACCEPT] + tally[STATUS_REJECT];
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic [1:0] req_tuser;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;

   // Shared between the sender and the receiver: a stretch with no idling on
   // either side, and the one long receiver hold-off.
   bit idle_off;
   bit hold_armed;
   bit hold_done;

   verdict_scoreboard sb;

   degree_minute_field_validator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_in
      .req_tuser  (req_tuser),   // [0] start_req, [1] is_longitude
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [1:0] status, [7:2] zero
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_char(input logic [7:0] c, input logic start, input logic longitude);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= {longitude, start};
      do @(posedge clock); while (!req_tready);
      sb.note_char(c, start, longitude);
   endtask

   task automatic send_string(input logic [7:0] chars[$], input bit longitude);
      foreach (chars[i]) begin
         if (i == 0) send_char(chars[i], 1'b1, longitude);
         else send_char(chars[i], 1'b0, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic send_text(input string s, input bit longitude);
      logic [7:0] chars[$];
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      send_string(chars, longitude);
   endtask

   // Builds a full-length position string with random content. In some strings, spaces
   // start at a random point, mostly at the separator or in the hundredths where they
   // can still pass; now and then one character is replaced by a random byte.
   function automatic void make_position(input bit longitude, ref logic [7:0] chars[$]);
      logic [7:0] lat_hemi[4] = '{CHAR_UP_N, CHAR_LO_N, CHAR_UP_S, CHAR_LO_S};
      logic [7:0] lon_hemi[4] = '{CHAR_UP_E, CHAR_LO_E, CHAR_UP_W, CHAR_LO_W};
      int         nd;
      int         len;
      int         sp;
      int         r;
      int         d;
      logic [7:0] ch;
      nd = longitude ? 3 : 2;
      len = nd + 6;
      r = $urandom_range(0, 9);
      if (r < 6) sp = len;
      else if (r < 8) sp = $urandom_range(nd + 2, nd + 4);
      else sp = $urandom_range(0, nd + 4);
      chars.delete();
      for (int i = 0; i < len; i++) begin
         if (i == nd + 2) begin
            if (i == sp) ch = CHAR_SPACE;
            else if (i < sp) ch = CHAR_DOT;
            else ch = $urandom_range(0, 1) ? CHAR_DOT : CHAR_SPACE;
         end else if (i == len - 1) begin
            if ($urandom_range(0, 7) == 0) ch = longitude ? lat_hemi[$urandom_range(0, 3)]
                                                          : lon_hemi[$urandom_range(0, 3)];
            else ch = longitude ? lon_hemi[$urandom_range(0, 3)] : lat_hemi[$urandom_range(0, 3)];
         end else if (i >= sp) begin
            ch = CHAR_SPACE;
         end else begin
            d = $urandom_range(0, 9);
            if (i == 0 && !longitude && $urandom_range(0, 5) != 0) d = $urandom_range(0, 8);
            if (i == 0 && longitude && $urandom_range(0, 5) != 0) d = $urandom_range(0, 1);
            if (i == 1 && longitude && chars[0] == CHAR_ZERO + 8'd1 &&
                $urandom_range(0, 3) != 0)
               d = $urandom_range(0, 7);
            if (i == nd && $urandom_range(0, 5) != 0) d = $urandom_range(0, 5);
            ch = CHAR_ZERO + 8'(d);
         end
         chars.push_back(ch);
      end
      if ($urandom_range(0, 5) == 0) chars[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
   endfunction

   // Receiver: one idle draw per response word, plus a single long hold-off.
   initial begin
      int gap;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = idle_off ? 0 : $urandom_range(0, MAX_IDLE);
         if (hold_armed && !hold_done) begin
            hold_done = 1;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_verdict(rsp_tdata);
      end
   end

   // Sender and the end of the run.
   initial begin
      logic [7:0] chars[$];
      bit         longitude;
      bit         paused;
      int         r;
      int         n;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      idle_off = 0;
      hold_armed = 0;
      hold_done = 0;
      paused = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a word with no string open, the largest legal latitude and
      // longitude with lower- and upper-case hemispheres, a start that abandons an
      // open string followed by a degree overflow, and a word after the verdict.
      send_char(8'hFF, 1'b0, 1'b1);
      send_text("8959.99n", 0);
      send_text("17959.99W", 1);
      send_char(CHAR_ZERO + 8'd1, 1'b1, 1'b0);
      send_text("90", 0);
      send_char(8'h00, 1'b0, 1'b0);
      send_text("4 ", 0);
      send_text("18000.00E", 1);

      // Random part, mostly well-formed strings with random content.
      while (sb.judged() < JUDGED_TARGET) begin
         if (sb.judged() >= 400) hold_armed = 1;
         if (sb.judged() >= 900 && !paused) begin
            // Stop offering words while the block drains completely.
            paused = 1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.pending_verdicts.size() != 0);
         end
         idle_off = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 75) begin
            longitude = $urandom_range(0, 1);
            make_position(longitude, chars);
            if ($urandom_range(0, 9) == 0) begin
               n = $urandom_range(1, chars.size() - 1);
               while (chars.size() > n) void'(chars.pop_back());
            end
            send_string(chars, longitude);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            repeat (n) send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         end else if (r < 90) begin
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            chars.delete();
            n = $urandom_range(1, 10);
            repeat (n) chars.push_back(8'($urandom_range(0, 255)));
            send_string(chars, 1'($urandom_range(0, 1)));
         end
      end
      idle_off = 0;
      req_tvalid <= 1'b0;

      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Checked %0d judged words: %0d strings accepted, %0d rejected, %0d ignored.",
               sb.judged(), sb.tally[STATUS_ACCEPT], sb.tally[STATUS_REJECT],
               sb.tally[STATUS_IGNORED]);
      $display("Run included idle-free bursts, one long response stall and one drain pause.");
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
